// File: rtl/rmr_pkg.sv
package rmr_pkg;

    // Operand bits taken from each input field (at most FIELD_W).
    localparam int VALUE_WIDTH = 16;
    localparam int FIELD_W     = 16;
    localparam int OP_W        = VALUE_WIDTH + 1;
    localparam int PROD_W      = 32;
    localparam int SUB_W       = PROD_W + 1;
    localparam int SHIFT_W     = $clog2(PROD_W);
    localparam int CNT_W       = $clog2(PROD_W);

    typedef struct packed {
        logic signed [FIELD_W-1:0] num_left;
        logic signed [FIELD_W-1:0] den_left;
        logic        [FIELD_W-1:0] root_left;
        logic signed [FIELD_W-1:0] num_right;
        logic signed [FIELD_W-1:0] den_right;
        logic        [FIELD_W-1:0] root_right;
    } rmr_item_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] num_product;
        logic signed [PROD_W-1:0] den_product;
        logic        [PROD_W-1:0] root_product;
        logic                     zero_den;
    } rmr_result_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_TWOS = 7'b0000100,
        ST_GCD  = 7'b0001000,
        ST_DIVN = 7'b0010000,
        ST_DIVD = 7'b0100000,
        ST_DONE = 7'b1000000
    } rmr_state_t;

    localparam logic [1:0] MUL_NUM  = 2'd0;
    localparam logic [1:0] MUL_DEN  = 2'd1;
    localparam logic [1:0] MUL_ROOT = 2'd2;

endpackage

// File: rtl/rational_multiply_reduce.sv
// Multiplies two operands of the form (num / den) * sqrt(root) and reduces the
// numerator and denominator products by the GCD of their magnitudes; each keeps
// its own sign and the radicand product passes through unsimplified. One item is
// in work at a time and item_stall stays high until it is finished. Products and
// differences come from one signed 17x17 multiplier and one 33-bit subtractor
// under a small sequencer: three multiplies, a binary GCD of shift, subtract or
// swap steps, and two 32-step restoring divisions. A zero product denominator
// skips reduction and goes straight to the done state. The result sits in an
// output register, so the next item is taken while the last result is stalled.
module rational_multiply_reduce
    import rmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  rmr_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output rmr_result_t result
);

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

    rmr_state_t state_reg, state_next;

    logic signed [OP_W-1:0] nl_reg, dl_reg, nr_reg, dr_reg;
    logic signed [OP_W-1:0] rl_reg, rr_reg;
    logic signed [OP_W-1:0] nl_next, dl_next, nr_next, dr_next;
    logic signed [OP_W-1:0] rl_next, rr_next;

    logic [1:0]         mcnt_reg, mcnt_next;
    logic [PROD_W-1:0]  n_reg, n_next, d_reg, d_next, root_reg, root_next;
    logic [PROD_W-1:0]  x_reg, x_next, y_reg, y_next, g_reg, g_next;
    logic [PROD_W-1:0]  nmag_reg, nmag_next, dmag_reg, dmag_next;
    logic [PROD_W-1:0]  quot_reg, quot_next, nq_reg, nq_next;
    logic [SUB_W-1:0]   rem_reg, rem_next;
    logic [SHIFT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               flag_reg, flag_next;

    logic        result_valid_reg, result_valid_next;
    rmr_result_t result_reg, result_next;

    logic                     item_xfer;
    logic                     out_load;
    logic signed [OP_W-1:0]   mul_a, mul_b;
    logic signed [2*OP_W-1:0] mul_full;
    logic [PROD_W-1:0]        mul_lo;
    logic [SUB_W-1:0]         sub_a, sub_b;
    logic [SUB_W:0]           sub_diff;
    logic                     sub_borrow;
    logic [PROD_W-1:0]        n_abs, d_abs, dq_final;

    assign item_xfer  = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign out_load   = !result_valid_reg || !result_stall;

    // Shared multiplier
    always_comb
    begin
        unique case (mcnt_reg)
            MUL_NUM:
            begin
                mul_a = nl_reg;
                mul_b = nr_reg;
            end
            MUL_DEN:
            begin
                mul_a = dl_reg;
                mul_b = dr_reg;
            end
            default:
            begin
                mul_a = rl_reg;
                mul_b = rr_reg;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_lo   = mul_full[PROD_W-1:0];

    // Shared subtractor: GCD compare/subtract or one restoring division step
    always_comb
    begin
        if (state_reg == ST_GCD)
        begin
            sub_a = {1'b0, x_reg};
            sub_b = {1'b0, y_reg};
        end
        else
        begin
            sub_a = {rem_reg[PROD_W-1:0], quot_reg[PROD_W-1]};
            sub_b = {1'b0, g_reg};
        end
    end

    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[SUB_W];

    assign n_abs    = n_reg[PROD_W-1] ? (~n_reg + 1'b1) : n_reg;
    assign d_abs    = d_reg[PROD_W-1] ? (~d_reg + 1'b1) : d_reg;
    assign dq_final = {quot_reg[PROD_W-2:0], !sub_borrow};

    always_comb
    begin
        state_next        = state_reg;
        nl_next           = nl_reg;
        dl_next           = dl_reg;
        rl_next           = rl_reg;
        nr_next           = nr_reg;
        dr_next           = dr_reg;
        rr_next           = rr_reg;
        mcnt_next         = mcnt_reg;
        n_next            = n_reg;
        d_next            = d_reg;
        root_next         = root_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        g_next            = g_reg;
        nmag_next         = nmag_reg;
        dmag_next         = dmag_reg;
        quot_next         = quot_reg;
        nq_next           = nq_reg;
        rem_next          = rem_reg;
        k_next            = k_reg;
        cnt_next          = cnt_reg;
        flag_next         = flag_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    nl_next = {{(OP_W-VALUE_WIDTH){item.num_left[VALUE_WIDTH-1]}},
                               item.num_left[VALUE_WIDTH-1:0]};
                    dl_next = {{(OP_W-VALUE_WIDTH){item.den_left[VALUE_WIDTH-1]}},
                               item.den_left[VALUE_WIDTH-1:0]};
                    nr_next = {{(OP_W-VALUE_WIDTH){item.num_right[VALUE_WIDTH-1]}},
                               item.num_right[VALUE_WIDTH-1:0]};
                    dr_next = {{(OP_W-VALUE_WIDTH){item.den_right[VALUE_WIDTH-1]}},
                               item.den_right[VALUE_WIDTH-1:0]};
                    rl_next = {{(OP_W-VALUE_WIDTH){1'b0}}, item.root_left[VALUE_WIDTH-1:0]};
                    rr_next = {{(OP_W-VALUE_WIDTH){1'b0}}, item.root_right[VALUE_WIDTH-1:0]};
                    mcnt_next  = MUL_NUM;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                mcnt_next = mcnt_reg + 2'd1;
                unique case (mcnt_reg)
                    MUL_NUM: n_next = mul_lo;
                    MUL_DEN: d_next = mul_lo;
                    default:
                    begin
                        root_next = mul_lo;
                        mcnt_next = MUL_NUM;
                        if (d_reg == '0)
                        begin
                            flag_next  = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            flag_next  = 1'b0;
                            x_next     = n_abs;
                            y_next     = d_abs;
                            nmag_next  = n_abs;
                            dmag_next  = d_abs;
                            k_next     = '0;
                            state_next = ST_TWOS;
                        end
                    end
                endcase
            end
            ST_TWOS:
            begin
                // strip the common power of two
                if ((x_reg != '0) && !x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                priority if (x_reg == '0)
                begin
                    g_next     = y_reg << k_reg;
                    quot_next  = nmag_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVN;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (!sub_borrow)
                begin
                    x_next = sub_diff[PROD_W-1:0];
                end
                else
                begin
                    // swap so the larger value is subtracted from next cycle
                    x_next = y_reg;
                    y_next = x_reg;
                end
            end
            ST_DIVN, ST_DIVD:
            begin
                rem_next  = sub_borrow ? sub_a : sub_diff[SUB_W-1:0];
                quot_next = dq_final;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (state_reg == ST_DIVN)
                    begin
                        nq_next    = dq_final;
                        quot_next  = dmag_reg;
                        state_next = ST_DIVD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    result_next.root_product = root_reg;
                    result_next.zero_den     = flag_reg;
                    if (flag_reg)
                    begin
                        result_next.num_product = n_reg;
                        result_next.den_product = d_reg;
                    end
                    else
                    begin
                        result_next.num_product = n_reg[PROD_W-1] ? (~nq_reg + 1'b1)
                                                                  : nq_reg;
                        result_next.den_product = d_reg[PROD_W-1] ? (~quot_reg + 1'b1)
                                                                  : quot_reg;
                    end
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mcnt_reg         <= MUL_NUM;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mcnt_reg         <= mcnt_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nl_reg     <= nl_next;
        dl_reg     <= dl_next;
        rl_reg     <= rl_next;
        nr_reg     <= nr_next;
        dr_reg     <= dr_next;
        rr_reg     <= rr_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        root_reg   <= root_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        g_reg      <= g_next;
        nmag_reg   <= nmag_next;
        dmag_reg   <= dmag_next;
        quot_reg   <= quot_next;
        nq_reg     <= nq_next;
        rem_reg    <= rem_next;
        k_reg      <= k_next;
        flag_reg   <= flag_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_item_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer |=> (state_reg == ST_MUL) && (mcnt_reg == MUL_NUM))
        else $error("accepted item did not start the multiply sequence");

    a_gcd_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GCD) |-> (y_reg != '0))
        else $error("GCD running with zero divisor operand");

    a_zero_flag_den: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.zero_den) |-> (result.den_product == '0))
        else $error("zero_den set with nonzero denominator");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.zero_den) |-> (result.den_product != '0))
        else $error("reduced denominator is zero");

endmodule

// File: dv/tb_rational_multiply_reduce.sv
`timescale 1ns / 100ps

module tb_rational_multiply_reduce;
    import rmr_pkg::*;

    typedef enum int {
        MIX_RAW,
        MIX_SHARED,
        MIX_SMALL,
        MIX_POW2,
        MIX_EDGE
    } operand_mix_t;

    localparam int MAX_REPORTS = 100;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    rmr_item_t   item;
    logic        result_valid;
    logic        result_stall;
    rmr_result_t result;

    rmr_result_t pending_products[$];
    rmr_result_t oldest_product;
    int          mismatch_count = 0;
    int          products_checked = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    int          hold_cycles = 0;
    int          stall_left = 0;

    rational_multiply_reduce DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Sign-extend the low VALUE_WIDTH bits of a field.
    function automatic longint field_signed(input logic [FIELD_W-1:0] raw);
        longint v;
        v = 0;
        v[FIELD_W-1:0] = raw;
        v = v & ((longint'(1) << VALUE_WIDTH) - 1);
        if (v[VALUE_WIDTH-1])
            v = v - (longint'(1) << VALUE_WIDTH);
        return v;
    endfunction

    function automatic longint unsigned field_unsigned(input logic [FIELD_W-1:0] raw);
        longint unsigned v;
        v = 0;
        v[FIELD_W-1:0] = raw;
        return v & ((longint'(1) << VALUE_WIDTH) - 1);
    endfunction

    function automatic rmr_result_t predict_product(input rmr_item_t it);
        longint          num;
        longint          den;
        longint          a;
        longint          b;
        longint          rem;
        longint unsigned root;
        rmr_result_t     r;
        num  = field_signed(it.num_left) * field_signed(it.num_right);
        den  = field_signed(it.den_left) * field_signed(it.den_right);
        root = field_unsigned(it.root_left) * field_unsigned(it.root_right);
        r.zero_den = (den == 0);
        if (den != 0)
        begin
            // divide magnitudes only, so each part keeps its own sign
            a = (num < 0) ? -num : num;
            b = (den < 0) ? -den : den;
            while (b != 0)
            begin
                rem = a % b;
                a   = b;
                b   = rem;
            end
            num = num / a;
            den = den / a;
        end
        r.num_product  = num[PROD_W-1:0];
        r.den_product  = den[PROD_W-1:0];
        r.root_product = root[PROD_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] mismatch on product %0d: %s", $realtime, products_checked, msg);
        mismatch_count++;
    endtask

    // Receiver: random stall bursts, plus a long hold-off on request.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_products.size() == 0)
                flag_mismatch("result transfer with no product pending");
            else
            begin
                oldest_product = pending_products.pop_front();
                if (result.num_product !== oldest_product.num_product)
                    flag_mismatch($sformatf("num_product %0d, predicted %0d",
                        result.num_product, oldest_product.num_product));
                if (result.den_product !== oldest_product.den_product)
                    flag_mismatch($sformatf("den_product %0d, predicted %0d",
                        result.den_product, oldest_product.den_product));
                if (result.root_product !== oldest_product.root_product)
                    flag_mismatch($sformatf("root_product %0d, predicted %0d",
                        result.root_product, oldest_product.root_product));
                if (result.zero_den !== oldest_product.zero_den)
                    flag_mismatch($sformatf("zero_den %b, predicted %b",
                        result.zero_den, oldest_product.zero_den));
            end
            products_checked++;
        end
    end

    function automatic rmr_item_t make_item(input int nl, input int dl, input int rl,
                                            input int nr, input int dr, input int rr);
        rmr_item_t it;
        it.num_left   = 16'(nl);
        it.den_left   = 16'(dl);
        it.root_left  = 16'(rl);
        it.num_right  = 16'(nr);
        it.den_right  = 16'(dr);
        it.root_right = 16'(rr);
        return it;
    endfunction

    function automatic int pick_operand(input operand_mix_t mix, input int factor);
        int v;
        case (mix)
            MIX_RAW:    v = $urandom_range(0, 65535) - 32768;
            MIX_SHARED: v = factor * $urandom_range(0, 32767 / factor);
            MIX_SMALL:  v = $urandom_range(0, 16) - 8;
            MIX_POW2:   v = 1 << $urandom_range(0, 15);
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = -1;
                    3:       v = 0;
                    4:       v = 1;
                    default: v = $urandom_range(0, 65535);
                endcase
            end
        endcase
        if (mix != MIX_RAW && mix != MIX_EDGE && $urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    function automatic int pick_root();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = 1;
            5:             v = 0;
            6:             v = 65535;
            default:       v = $urandom_range(0, 65535);
        endcase
        return v;
    endfunction

    function automatic rmr_item_t random_item();
        operand_mix_t mix;
        int           factor;
        case ($urandom_range(0, 9))
            0, 1, 2:    mix = MIX_RAW;
            3, 4, 5, 6: mix = MIX_SHARED;
            7:          mix = MIX_SMALL;
            8:          mix = MIX_POW2;
            default:    mix = MIX_EDGE;
        endcase
        // in the shared mix, a common factor across all four values makes the reduction do real work
        factor = $urandom_range(2, 255);
        return make_item(pick_operand(mix, factor), pick_operand(mix, factor), pick_root(),
                         pick_operand(mix, factor), pick_operand(mix, factor), pick_root());
    endfunction

    // Called at a rising edge; returns at the edge of the transfer or after an idle gap.
    task automatic send_item(input rmr_item_t it);
        int gap;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        pending_products.push_back(predict_product(it));
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic test_directed();
        send_item(make_item(1, 1, 1, 1, 1, 1));
        send_item(make_item(-32768, -32768, 65535, -32768, -32768, 65535));
        send_item(make_item(32767, -32768, 0, 32767, 32767, 1));
        send_item(make_item(-32768, 32767, 1, 32767, -32768, 1));
        // zero numerator: 0 over +1 or -1
        send_item(make_item(0, 5, 1, 7, 3, 1));
        send_item(make_item(0, -5, 1, 7, 3, 1));
        send_item(make_item(0, -32768, 65535, -32768, 1, 65535));
        // zero denominator product: raw numerator, flag set
        send_item(make_item(0, 0, 1, 3, 4, 1));
        send_item(make_item(6, 0, 2, -4, 9, 3));
        send_item(make_item(-32768, 0, 1, -32768, -32768, 1));
        // signs stay where they are
        send_item(make_item(-6, 4, 1, 10, -15, 1));
        send_item(make_item(12, 18, 5, 35, -14, 7));
        send_item(make_item(-17, -13, 3, 13, 17, 3));
        send_item(make_item(-32768, 1, 1, 1, -32768, 1));
        send_item(make_item(3, -3, 2, -3, 3, 8));
        // zero radicand
        send_item(make_item(-1, -1, 65535, -1, -1, 0));
        send_item(make_item(32767, 1, 1, 32767, 1, 1));
        send_item(make_item(1, 32767, 1, 1, 32767, 1));
        send_item(make_item(4096, -2, 1, 8, -1024, 1));
        send_item(make_item(7, 11, 1, 13, 17, 1));
    endtask

    // Hold the output long enough that the block fills and stalls its input.
    task automatic test_output_hold();
        hold_cycles = 600;
        repeat (24) send_item(random_item());
    endtask

    task automatic test_drain_pause();
        repeat (2)
        begin
            repeat (15) send_item(random_item());
            item_valid <= 1'b0;
            while (pending_products.size() != 0)
                @(posedge clk);
            @(posedge clk);
        end
    endtask

    task automatic test_random_mix();
        repeat (8)
        begin
            tx_idle_en = $urandom_range(0, 2) != 0;
            rx_idle_en = $urandom_range(0, 2) != 0;
            repeat (210) send_item(random_item());
        end
    endtask

    task automatic test_streaming();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (100) send_item(random_item());
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_output_hold();
        test_drain_pause();
        test_random_mix();
        test_streaming();

        item_valid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && pending_products.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
